// File: design/aimd_congestion_window_assert.svh
// Assertion macros shared by the congestion window checker.
`ifndef AIMD_CONGESTION_WINDOW_ASSERT_SVH
`define AIMD_CONGESTION_WINDOW_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define ACW_ASSERT_IMP(lbl, clk_i, rstn_i, ante, cons, msg) \
    lbl: assert property (@(posedge clk_i) disable iff (!(rstn_i)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked during reset.
`define ACW_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons, msg) \
    lbl: assert property (@(posedge clk_i) disable iff (!(rstn_i)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/acw_pkg.sv
// Package: types and constants of the congestion window controller.
`default_nettype none
package acw_pkg;

    // Sequence width default and the fixed width of the sequence fields.
    localparam int SEQ_WIDTH_DEF = 64;
    localparam int SEQ_FIELD_W   = 64;

    localparam int WIN_W       = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    // Register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_WINDOW = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_WINDOW     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CONG_GAP       = 2'd2;

    // Register reset values.
    localparam logic [WIN_W-1:0] INITIAL_WINDOW_RST = 8'd4;
    localparam logic [WIN_W-1:0] MAX_WINDOW_RST     = 8'd32;
    localparam logic [WIN_W-1:0] CONG_GAP_RST       = 8'd5;

    typedef enum logic [1:0] {
        CMD_REPLY   = 2'd0,
        CMD_TIMEOUT = 2'd1,
        CMD_QUERY   = 2'd2,
        CMD_RESET   = 2'd3
    } cmd_e;

    typedef struct packed {
        logic [1:0]             command;
        logic [SEQ_FIELD_W-1:0] sequence_req;
        logic [SEQ_FIELD_W-1:0] acked_sequence;
    } cmd_item_t;

    typedef struct packed {
        logic             can_send;
        logic             duplicate_reply;
        logic [WIN_W-1:0] window_now;
        logic             recovering;
    } res_item_t;

    typedef struct packed {
        logic [WIN_W-1:0] initial_window;
        logic [WIN_W-1:0] max_window;
        logic [WIN_W-1:0] cong_gap;
    } cfg_t;

endpackage
`default_nettype wire

// File: design/acw_cfg.sv
// Configuration register file of the congestion window controller.
`default_nettype none
module acw_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [acw_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [acw_pkg::CFG_DATA_W-1:0]  cfg_data,
    output acw_pkg::cfg_t                       cfg
);
    import acw_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_INITIAL_WINDOW: cfg_next.initial_window = cfg_data;
                CFG_MAX_WINDOW:     cfg_next.max_window     = cfg_data;
                CFG_CONG_GAP:       cfg_next.cong_gap       = cfg_data;
                default:            cfg_next = cfg_reg;  // unused index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.initial_window <= INITIAL_WINDOW_RST;
            cfg_reg.max_window     <= MAX_WINDOW_RST;
            cfg_reg.cong_gap       <= CONG_GAP_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// File: design/acw_core.sv
// Per-item update logic: next window state and the result item.
`default_nettype none
module acw_core #(
    parameter int SEQ_WIDTH = acw_pkg::SEQ_WIDTH_DEF
) (
    input  wire acw_pkg::cmd_item_t          item,
    input  wire acw_pkg::cfg_t               cfg,
    input  wire logic [acw_pkg::WIN_W-1:0]   window,
    input  wire logic [SEQ_WIDTH-1:0]        last_reply,
    input  wire logic                        in_recovery,
    output logic [acw_pkg::WIN_W-1:0]        window_upd,
    output logic [SEQ_WIDTH-1:0]             last_reply_upd,
    output logic                             recovery_upd,
    output acw_pkg::res_item_t               res
);
    import acw_pkg::*;

    logic [SEQ_WIDTH-1:0] seq;
    logic [SEQ_WIDTH-1:0] acked;
    logic [SEQ_WIDTH-1:0] reply_diff;
    logic [SEQ_WIDTH-1:0] query_diff;
    logic                 query_idle;
    logic                 dup;
    logic                 congested;
    logic [WIN_W-1:0]     halved;
    logic [WIN_W:0]       grown;
    logic [WIN_W-1:0]     grown_capped;
    logic                 can_send;

    assign seq   = item.sequence_req[SEQ_WIDTH-1:0];
    assign acked = item.acked_sequence[SEQ_WIDTH-1:0];

    // Reply age, modulo the sequence space, read as signed.
    assign reply_diff = seq - last_reply;
    assign dup        = (reply_diff == '0) || reply_diff[SEQ_WIDTH-1];
    // gap is diff - 1, so gap >= threshold is diff > threshold for a newer reply
    assign congested  = reply_diff > SEQ_WIDTH'(cfg.cong_gap);

    // Multiplicative decrease, floor of one.
    assign halved = (window[WIN_W-1:1] == '0) ? WIN_W'(1) : {1'b0, window[WIN_W-1:1]};

    // Additive increase, capped.
    assign grown        = {1'b0, window} + (WIN_W+1)'(1);
    assign grown_capped = (grown < {1'b0, cfg.max_window}) ? grown[WIN_W-1:0]
                                                           : cfg.max_window;

    // Send query: nothing outstanding unless next is more than one ahead;
    // otherwise d - 1 < window is d <= window.
    assign query_diff = seq - acked;
    assign query_idle = query_diff[SEQ_WIDTH-1] || (query_diff <= SEQ_WIDTH'(1));
    assign can_send   = query_idle ? (window != '0) : (query_diff <= SEQ_WIDTH'(window));

    always_comb
    begin
        window_upd          = window;
        last_reply_upd      = last_reply;
        recovery_upd        = in_recovery;
        res.can_send        = 1'b0;
        res.duplicate_reply = 1'b0;
        case (cmd_e'(item.command))
            CMD_REPLY:
            begin
                if (dup)
                begin
                    res.duplicate_reply = 1'b1;
                end
                else
                begin
                    last_reply_upd = seq;
                    // a congestion event enters recovery and this same reply leaves it
                    recovery_upd   = 1'b0;
                    if (congested)
                    begin
                        window_upd = halved;
                    end
                    else if (!in_recovery)
                    begin
                        window_upd = grown_capped;
                    end
                end
            end
            CMD_TIMEOUT:
            begin
                window_upd   = halved;
                recovery_upd = 1'b1;
            end
            CMD_QUERY:
            begin
                res.can_send = can_send;
            end
            CMD_RESET:
            begin
                window_upd     = cfg.initial_window;
                last_reply_upd = '0;
                recovery_upd   = 1'b0;
            end
            default:
            begin
                window_upd = window;
            end
        endcase
        res.window_now = window_upd;
        res.recovering = recovery_upd;
    end

endmodule
`default_nettype wire

// File: design/aimd_congestion_window.sv
// Top level of the AIMD congestion window controller.
// AIMD congestion window controller. Each command item (reply, timeout, send
// query, reset) gives exactly one result item carrying the window and the
// recovery flag after that command. An item is taken into an input register;
// when it moves on, the window state and the result register are updated from
// it, so its result is offered from the cycle after it moves on. One item is
// taken every cycle while results are taken; while res_stall holds the result
// register one more item waits in the input register, and the input stalls
// only when both are full. Replies that are not newer than the last one are
// flagged as duplicates and change nothing. initial_window is used only at
// reset and by the reset command; max_window and cong_gap act at once.
`default_nettype none
module aimd_congestion_window #(
    parameter int SEQ_WIDTH = acw_pkg::SEQ_WIDTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // command channel
    input  wire logic                            cmd_valid,
    output logic                                 cmd_stall,
    input  wire acw_pkg::cmd_item_t              cmd_item,
    // result channel
    output logic                                 res_valid,
    input  wire logic                            res_stall,
    output acw_pkg::res_item_t                   res_item,
    // configuration write port
    input  wire logic                            cfg_we,
    input  wire logic [acw_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [acw_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import acw_pkg::*;

    cfg_t cfg;

    // input stage
    logic      s1_valid_reg;
    logic      s1_valid_next;
    cmd_item_t s1_item_reg;

    // result stage
    logic      res_valid_reg;
    logic      res_valid_next;
    res_item_t res_item_reg;

    // window state
    logic [WIN_W-1:0]     window_reg;
    logic [SEQ_WIDTH-1:0] last_reply_reg;
    logic                 recovery_reg;

    logic [WIN_W-1:0]     window_next;
    logic [SEQ_WIDTH-1:0] last_reply_next;
    logic                 recovery_next;
    res_item_t            res_next;

    logic cmd_accept;
    logic advance;

    acw_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    acw_core #(
        .SEQ_WIDTH (SEQ_WIDTH)
    ) u_core (
        .item           (s1_item_reg),
        .cfg            (cfg),
        .window         (window_reg),
        .last_reply     (last_reply_reg),
        .in_recovery    (recovery_reg),
        .window_upd     (window_next),
        .last_reply_upd (last_reply_next),
        .recovery_upd   (recovery_next),
        .res            (res_next)
    );

    // The held item moves on when the result register is free or being emptied.
    assign advance    = s1_valid_reg && (!res_valid_reg || !res_stall);
    assign cmd_stall  = s1_valid_reg && !advance;
    assign cmd_accept = cmd_valid && !cmd_stall;

    assign s1_valid_next  = cmd_accept || (s1_valid_reg && !advance);
    assign res_valid_next = advance || (res_valid_reg && res_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            res_valid_reg  <= 1'b0;
            window_reg     <= INITIAL_WINDOW_RST;
            last_reply_reg <= '0;
            recovery_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            if (advance)
            begin
                window_reg     <= window_next;
                last_reply_reg <= last_reply_next;
                recovery_reg   <= recovery_next;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            s1_item_reg <= cmd_item;
        end
        if (advance)
        begin
            res_item_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

endmodule
`default_nettype wire

// File: design/acw_checker.sv
// Port-level checker for the congestion window controller, bound to the top.
`default_nettype none
`include "aimd_congestion_window_assert.svh"
module acw_checker (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    input  wire logic           cmd_stall,
    input  wire logic           res_valid,
    input  wire logic           res_stall,
    input  wire acw_pkg::res_item_t res_item
);
    import acw_pkg::*;

    logic             res_accept;
    logic             prev_valid_reg;
    logic [WIN_W-1:0] prev_window_reg;
    logic             prev_rec_reg;

    assign res_accept = res_valid && !res_stall;

    // last delivered window state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_valid_reg  <= 1'b0;
            prev_window_reg <= '0;
            prev_rec_reg    <= 1'b0;
        end
        else if (res_accept)
        begin
            prev_valid_reg  <= 1'b1;
            prev_window_reg <= res_item.window_now;
            prev_rec_reg    <= res_item.recovering;
        end
    end

    `ACW_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && res_stall,
        res_valid && $stable(res_item), "stalled result item changed")
    `ACW_ASSERT_IMP(a_stall_needs_result, clk, rst_n, cmd_valid && cmd_stall,
        res_valid && res_stall, "command stalled with the result side free")
    `ACW_ASSERT_IMP(a_dup_no_change, clk, rst_n, res_accept && res_item.duplicate_reply && prev_valid_reg,
        (res_item.window_now == prev_window_reg) && (res_item.recovering == prev_rec_reg),
        "duplicate reply changed the window state")
    `ACW_ASSERT_IMP(a_recovery_window, clk, rst_n, res_valid && res_item.recovering,
        (res_item.window_now != '0) && !res_item.duplicate_reply || res_item.duplicate_reply,
        "window zero while in recovery")
    `ACW_ASSERT_IMP(a_flags_exclusive, clk, rst_n, res_valid,
        !(res_item.can_send && res_item.duplicate_reply), "query and reply flags both set")

endmodule

bind aimd_congestion_window acw_checker u_acw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
);
`default_nettype wire
